/* rtl/stru_pkg.sv */
// Shared constants, register codes and types of the Student t ratio-of-uniforms sampler.
`default_nettype none
package stru_pkg;

  localparam int OUT_FRAC_BITS = 16;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  localparam int DIV_STAGES  = 64;
  localparam int NORM_STAGES = 6;
  localparam int LOG_FRAC    = 32;
  localparam int LOG_LAT     = NORM_STAGES + LOG_FRAC;

  typedef enum logic [2:0] {
    REG_RATIO_SCALE,
    REG_SQUEEZE_COEFF,
    REG_REJECT_BOUND,
    REG_INVERSE_DOF,
    REG_POWER_EXPONENT,
    REG_DOF_AT_LEAST_THREE
  } reg_idx_t;

  // classified request: u plus 2v-1 as sign and magnitude
  typedef struct packed {
    logic [31:0] u;
    logic        neg;
    logic [32:0] wmag;
  } stru_item_t;

  typedef struct packed {
    logic [31:0]        ratio_scale;
    logic [31:0]        squeeze_coeff;
    logic [31:0]        reject_bound;
    logic [31:0]        inverse_dof;
    logic signed [31:0] power_exponent;
    logic               dof_at_least_three;
  } stru_cfg_t;

endpackage
`default_nettype wire

/* rtl/stru_front.sv */
// Front end: takes requests, drops zero u, forms the sign and magnitude of 2v-1.
`default_nettype none
module stru_front import stru_pkg::*; (
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_u_uniform,
  input  wire logic [31:0] in_v_uniform,
  input  wire logic        q_full,
  output logic             q_push,
  output stru_item_t       q_item
);

  logic        accept;
  logic [32:0] v2;

  always_comb begin
    accept   = in_valid & ~q_full;
    in_stall = q_full;
    // zero u is rejected outright
    q_push   = accept & (in_u_uniform != 32'd0);
    v2       = {in_v_uniform, 1'b0};
    q_item.u   = in_u_uniform;
    q_item.neg = ~in_v_uniform[31];
    if (q_item.neg) begin
      q_item.wmag = 33'h1_0000_0000 - v2;
    end else begin
      q_item.wmag = v2 - 33'h1_0000_0000;
    end
  end

endmodule
`default_nettype wire

/* rtl/stru_queue.sv */
// Short request queue between the front end and the arithmetic pipeline.
`default_nettype none
module stru_queue import stru_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire stru_item_t push_item,
  input  wire logic       pop,
  output logic            full,
  output logic            empty,
  output stru_item_t      head
);

  stru_item_t       buf_r [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_r;
  logic [Q_AW-1:0]  rd_ptr_r;
  logic [Q_AW:0]    count_r;
  logic [Q_AW:0]    count_nxt;

  always_comb begin
    full  = (count_r == (Q_AW+1)'(Q_DEPTH));
    empty = (count_r == '0);
    head  = buf_r[rd_ptr_r];
    count_nxt = count_r + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop) else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (Q_AW+1)'(Q_DEPTH)) else $error("queue count out of range");
`endif

endmodule
`default_nettype wire

/* rtl/stru_log2.sv */
// Pipelined log2 with 32 fraction bits: staged normalize, then one mantissa square per stage.
`default_nettype none
module stru_log2 import stru_pkg::*; (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [63:0] x_in,
  output logic [37:0]      log_out
);

  logic [63:0]         nx_r  [NORM_STAGES];
  logic [5:0]          nn_r  [NORM_STAGES];
  logic [63:0]         xi    [NORM_STAGES];
  logic [5:0]          ni    [NORM_STAGES];

  logic [31:0]         m_r   [LOG_FRAC];
  logic [5:0]          sn_r  [LOG_FRAC];
  logic [LOG_FRAC-1:0] f_r   [LOG_FRAC];
  logic [31:0]         mi    [LOG_FRAC];
  logic [5:0]          si    [LOG_FRAC];
  logic [LOG_FRAC-1:0] fi    [LOG_FRAC];
  logic [32:0]         m2    [LOG_FRAC];

  always_comb begin
    xi[0] = x_in;
    ni[0] = 6'd63;
    for (int k = 1; k < NORM_STAGES; k++) begin
      xi[k] = nx_r[k-1];
      ni[k] = nn_r[k-1];
    end
    mi[0] = nx_r[NORM_STAGES-1][63:32];
    si[0] = nn_r[NORM_STAGES-1];
    fi[0] = '0;
    for (int j = 1; j < LOG_FRAC; j++) begin
      mi[j] = m_r[j-1];
      si[j] = sn_r[j-1];
      fi[j] = f_r[j-1];
    end
    for (int j = 0; j < LOG_FRAC; j++) begin
      m2[j] = 33'((64'(mi[j]) * 64'(mi[j])) >> 31);
    end
    log_out = {sn_r[LOG_FRAC-1], f_r[LOG_FRAC-1]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // shift out leading zeros, largest step first
      for (int k = 0; k < NORM_STAGES; k++) begin
        if ((xi[k] >> (64 - (1 << (NORM_STAGES-1-k)))) == 64'd0) begin
          nx_r[k] <= xi[k] << (1 << (NORM_STAGES-1-k));
          nn_r[k] <= ni[k] - 6'(1 << (NORM_STAGES-1-k));
        end else begin
          nx_r[k] <= xi[k];
          nn_r[k] <= ni[k];
        end
      end
      for (int j = 0; j < LOG_FRAC; j++) begin
        sn_r[j] <= si[j];
        if (m2[j][32]) begin
          m_r[j] <= m2[j][32:1];
          f_r[j] <= {fi[j][LOG_FRAC-2:0], 1'b1};
        end else begin
          m_r[j] <= m2[j][31:0];
          f_r[j] <= {fi[j][LOG_FRAC-2:0], 1'b0};
        end
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/stru_back.sv */
// Arithmetic pipeline: ratio, divide, square, squeeze and reject tests, log test, output.
`default_nettype none
module stru_back import stru_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire stru_cfg_t   cfg,
  input  wire logic        q_empty,
  input  wire stru_item_t  q_head,
  output logic             q_pop,
  input  wire logic        out_stall,
  output logic             out_valid,
  output logic signed [31:0] out_sample,
  output logic             out_saturated
);

  typedef struct packed {
    logic        qa;
    logic        rej;
    logic        neg;
    logic [63:0] tmag;
  } side_t;

  localparam logic [63:0] FIVE   = 64'd5 << 32;
  localparam logic [63:0] THREE  = 64'd3 << 32;
  localparam logic [63:0] ONE    = 64'd1 << 32;
  localparam logic [37:0] LOG_32 = 38'd32 << 32;
  localparam int SH   = 30 - OUT_FRAC_BITS;
  localparam int SH_R = (SH >= 0) ? SH : 0;
  localparam int SH_L = (SH < 0) ? -SH : 0;

  logic adv;

  // ratio numerator
  logic        m_vld_r;
  logic [63:0] m_prod_r;
  logic [31:0] m_u_r;
  logic        m_neg_r;

  // restoring divider, one quotient bit per stage
  logic        d_vld_r [DIV_STAGES];
  logic [31:0] d_rem_r [DIV_STAGES];
  logic [63:0] d_q_r   [DIV_STAGES];
  logic [31:0] d_u_r   [DIV_STAGES];
  logic        d_neg_r [DIV_STAGES];
  logic        di_vld  [DIV_STAGES];
  logic [31:0] di_rem  [DIV_STAGES];
  logic [63:0] di_q    [DIV_STAGES];
  logic [31:0] di_u    [DIV_STAGES];
  logic        di_neg  [DIV_STAGES];
  logic [32:0] dt      [DIV_STAGES];
  logic        dge     [DIV_STAGES];

  logic [63:0] tmag;

  logic        s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, s5_vld_r;
  logic [63:0] s1_p00_r, s1_p01_r, s1_p11_r, s1_cu_r;
  logic [63:0] s1_tmag_r, s2_tmag_r, s3_tmag_r, s4_tmag_r, s5_tmag_r;
  logic [31:0] s1_u_r, s2_u_r, s3_u_r, s4_u_r, s5_u_r;
  logic        s1_neg_r, s2_neg_r, s3_neg_r, s4_neg_r, s5_neg_r;
  logic [63:0] s2_sq_r, s2_cu_r;
  logic        s3_qa_r, s4_qa_r, s5_qa_r;
  logic [63:0] s3_x_r, s3_sq_r;
  logic [63:0] s4_ux_lo_r, s4_ux_hi_r, s4_sr_lo_r, s4_sr_hi_r;
  logic        s5_rej_r;
  logic [63:0] s5_prod_r;

  logic [127:0] sq_full;
  logic [63:0]  sq_nxt;
  logic         qa_nxt;
  logic [64:0]  x_sum;
  logic [95:0]  ux;
  logic [95:0]  sr;
  logic [64:0]  y_sum;
  logic [63:0]  y_val;

  logic         l_vld_r [LOG_LAT];
  side_t        l_side_r [LOG_LAT];
  logic [37:0]  lu_log, ly_log;

  logic         f1_vld_r, f2_vld_r;
  side_t        f1_side_r, f2_side_r;
  logic [37:0]  f1_a_r, f1_ly_r, f2_a_r;
  logic [69:0]  f2_prod_r;
  logic [31:0]  qm;

  logic         fin, accept, sat_nxt;
  logic [63:0]  mag;
  logic [31:0]  sample_nxt;

  logic         out_valid_r;
  logic [31:0]  out_sample_r;
  logic         out_saturated_r;

  // the whole pipeline advances unless a finished result is held
  assign adv   = ~out_valid_r | ~out_stall;
  assign q_pop = adv & ~q_empty;

  always_comb begin
    di_vld[0] = m_vld_r;
    di_rem[0] = '0;
    di_q[0]   = m_prod_r;
    di_u[0]   = m_u_r;
    di_neg[0] = m_neg_r;
    for (int i = 1; i < DIV_STAGES; i++) begin
      di_vld[i] = d_vld_r[i-1];
      di_rem[i] = d_rem_r[i-1];
      di_q[i]   = d_q_r[i-1];
      di_u[i]   = d_u_r[i-1];
      di_neg[i] = d_neg_r[i-1];
    end
    for (int i = 0; i < DIV_STAGES; i++) begin
      dt[i]  = {di_rem[i], di_q[i][63]};
      dge[i] = (dt[i] >= {1'b0, di_u[i]});
    end
    tmag = d_q_r[DIV_STAGES-1];
  end

  always_comb begin
    sq_full = (128'(s1_p11_r) << 64) + (128'(s1_p01_r) << 33) + 128'(s1_p00_r);
    sq_nxt  = (sq_full[127:92] != '0) ? '1 : sq_full[91:28];
    qa_nxt  = (s2_sq_r <= FIVE) && (s2_cu_r <= ((FIVE - s2_sq_r) << 28));
    x_sum   = 65'(s2_sq_r) + 65'(THREE);
    ux      = (96'(s4_ux_hi_r) << 32) + 96'(s4_ux_lo_r);
    sr      = (96'(s4_sr_hi_r) << 32) + 96'(s4_sr_lo_r);
    y_sum   = 65'(s5_prod_r) + 65'(ONE);
    y_val   = y_sum[64] ? '1 : y_sum[63:0];
  end

  stru_log2 u_log_u (
    .clk     (clk),
    .en      (adv),
    .x_in    ({32'd0, s5_u_r}),
    .log_out (lu_log)
  );

  stru_log2 u_log_y (
    .clk     (clk),
    .en      (adv),
    .x_in    (y_val),
    .log_out (ly_log)
  );

  // control: valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r  <= 1'b0;
      for (int i = 0; i < DIV_STAGES; i++) begin
        d_vld_r[i] <= 1'b0;
      end
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
      for (int i = 0; i < LOG_LAT; i++) begin
        l_vld_r[i] <= 1'b0;
      end
      f1_vld_r    <= 1'b0;
      f2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      m_vld_r <= q_pop;
      for (int i = 0; i < DIV_STAGES; i++) begin
        d_vld_r[i] <= di_vld[i];
      end
      s1_vld_r <= d_vld_r[DIV_STAGES-1];
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
      l_vld_r[0] <= s5_vld_r;
      for (int i = 1; i < LOG_LAT; i++) begin
        l_vld_r[i] <= l_vld_r[i-1];
      end
      f1_vld_r    <= l_vld_r[LOG_LAT-1];
      f2_vld_r    <= f1_vld_r;
      out_valid_r <= f2_vld_r & accept;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (adv) begin
      m_prod_r <= 64'(cfg.ratio_scale) * 64'(q_head.wmag);
      m_u_r    <= q_head.u;
      m_neg_r  <= q_head.neg;

      for (int i = 0; i < DIV_STAGES; i++) begin
        d_rem_r[i] <= dge[i] ? 32'(dt[i] - {1'b0, di_u[i]}) : dt[i][31:0];
        d_q_r[i]   <= {di_q[i][62:0], dge[i]};
        d_u_r[i]   <= di_u[i];
        d_neg_r[i] <= di_neg[i];
      end

      s1_p00_r  <= 64'(tmag[31:0])  * 64'(tmag[31:0]);
      s1_p01_r  <= 64'(tmag[31:0])  * 64'(tmag[63:32]);
      s1_p11_r  <= 64'(tmag[63:32]) * 64'(tmag[63:32]);
      s1_cu_r   <= 64'(cfg.squeeze_coeff) * 64'(d_u_r[DIV_STAGES-1]);
      s1_tmag_r <= tmag;
      s1_u_r    <= d_u_r[DIV_STAGES-1];
      s1_neg_r  <= d_neg_r[DIV_STAGES-1];

      s2_sq_r   <= sq_nxt;
      s2_cu_r   <= s1_cu_r;
      s2_tmag_r <= s1_tmag_r;
      s2_u_r    <= s1_u_r;
      s2_neg_r  <= s1_neg_r;

      s3_qa_r   <= qa_nxt;
      s3_x_r    <= x_sum[64] ? '1 : x_sum[63:0];
      s3_sq_r   <= s2_sq_r;
      s3_tmag_r <= s2_tmag_r;
      s3_u_r    <= s2_u_r;
      s3_neg_r  <= s2_neg_r;

      s4_ux_lo_r <= 64'(s3_u_r) * 64'(s3_x_r[31:0]);
      s4_ux_hi_r <= 64'(s3_u_r) * 64'(s3_x_r[63:32]);
      s4_sr_lo_r <= 64'(s3_sq_r[31:0])  * 64'(cfg.inverse_dof);
      s4_sr_hi_r <= 64'(s3_sq_r[63:32]) * 64'(cfg.inverse_dof);
      s4_qa_r    <= s3_qa_r;
      s4_tmag_r  <= s3_tmag_r;
      s4_u_r     <= s3_u_r;
      s4_neg_r   <= s3_neg_r;

      s5_rej_r  <= (ux >= (96'(cfg.reject_bound) << 36));
      s5_prod_r <= (sr[95:94] != 2'd0) ? '1 : sr[93:30];
      s5_qa_r   <= s4_qa_r;
      s5_tmag_r <= s4_tmag_r;
      s5_u_r    <= s4_u_r;
      s5_neg_r  <= s4_neg_r;

      l_side_r[0] <= '{qa: s5_qa_r, rej: s5_rej_r, neg: s5_neg_r, tmag: s5_tmag_r};
      for (int i = 1; i < LOG_LAT; i++) begin
        l_side_r[i] <= l_side_r[i-1];
      end

      f1_side_r <= l_side_r[LOG_LAT-1];
      f1_a_r    <= LOG_32 - lu_log;
      f1_ly_r   <= ly_log - LOG_32;

      f2_side_r <= f1_side_r;
      f2_a_r    <= f1_a_r;
      f2_prod_r <= 70'(qm) * 70'(f1_ly_r);

      if (f2_vld_r & accept) begin
        out_sample_r    <= sample_nxt;
        out_saturated_r <= sat_nxt;
      end
    end
  end

  always_comb begin
    qm  = 32'(33'h1_0000_0000 - {1'b0, cfg.power_exponent});
    fin = (f2_prod_r <= (70'(f2_a_r) << 16));
    accept = f2_side_r.qa |
             (~(cfg.dof_at_least_three & f2_side_r.rej) &
              (~cfg.power_exponent[31] | fin));
    if (SH >= 0) begin
      mag = f2_side_r.tmag >> SH_R;
    end else if (f2_side_r.tmag > (64'd1 << 33)) begin
      mag = 64'd1 << 35;
    end else begin
      mag = f2_side_r.tmag << SH_L;
    end
    sat_nxt = 1'b0;
    if (f2_side_r.neg) begin
      if (mag > 64'h8000_0000) begin
        sample_nxt = 32'h8000_0000;
        sat_nxt    = 1'b1;
      end else begin
        sample_nxt = 32'(64'd0 - mag);
      end
    end else begin
      if (mag > 64'h7FFF_FFFF) begin
        sample_nxt = 32'h7FFF_FFFF;
        sat_nxt    = 1'b1;
      end else begin
        sample_nxt = mag[31:0];
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_sample    = out_sample_r;
  assign out_saturated = out_saturated_r;

`ifndef SYNTH
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_saturated_r |->
      (out_sample_r == 32'h7FFF_FFFF || out_sample_r == 32'h8000_0000))
    else $error("saturated result not at a range end");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !q_pop ##1 (out_valid_r && $stable(out_sample_r)))
    else $error("pipeline moved while result held");
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid_r && !m_vld_r)
    else $error("valid bits not cleared by reset");
`endif

endmodule
`default_nettype wire

/* rtl/student_t_ratio_uniforms_sampler_core.sv */
// Top level of the Student t ratio-of-uniforms sampler: registers, front end, queue, pipeline.
//
//   channel | ports                               | direction | handshake
//   --------+-------------------------------------+-----------+----------------------
//   input   | in_u_uniform, in_v_uniform          | in        | in_valid / in_stall
//   result  | out_sample, out_saturated           | out       | out_valid / out_stall
//   config  | psel penable pwrite paddr pwdata    | in/out    | APB, pready always 1
//
// One request per cycle is accepted while in_stall is low; a result (if the trial accepts) passes
// through the 64-stage divider and the two 38-stage log units before it appears.
// A held result stalls the whole arithmetic pipeline; the 4-entry queue absorbs requests
// until it fills, then in_stall rises. Rejected pairs and zero u give no result.
// rst_n is synchronous and clears valid bits and registers to their defaults.
`default_nettype none
module student_t_ratio_uniforms_sampler_core import stru_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_u_uniform,
  input  wire logic [31:0] in_v_uniform,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [31:0] out_sample,
  output logic             out_saturated,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [31:0] ratio_scale_r;
  logic [31:0] squeeze_coeff_r;
  logic [31:0] reject_bound_r;
  logic [31:0] inverse_dof_r;
  logic [31:0] power_exponent_r;
  logic        dof_at_least_three_r;

  stru_cfg_t   cfg;
  reg_idx_t    reg_idx;
  logic        wr_en;

  logic        q_full, q_empty, q_push, q_pop;
  stru_item_t  q_in, q_head;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[4:2]);
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_scale_r        <= 32'd1073741824;
      squeeze_coeff_r      <= 32'd1518500250;
      reject_bound_r       <= 32'd759250125;
      inverse_dof_r        <= 32'd1073741824;
      power_exponent_r     <= 32'hFFFF_8000;
      dof_at_least_three_r <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_RATIO_SCALE:        ratio_scale_r        <= pwdata;
        REG_SQUEEZE_COEFF:      squeeze_coeff_r      <= pwdata;
        REG_REJECT_BOUND:       reject_bound_r       <= pwdata;
        REG_INVERSE_DOF:        inverse_dof_r        <= pwdata;
        REG_POWER_EXPONENT:     power_exponent_r     <= pwdata;
        REG_DOF_AT_LEAST_THREE: dof_at_least_three_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_RATIO_SCALE:        prdata = ratio_scale_r;
      REG_SQUEEZE_COEFF:      prdata = squeeze_coeff_r;
      REG_REJECT_BOUND:       prdata = reject_bound_r;
      REG_INVERSE_DOF:        prdata = inverse_dof_r;
      REG_POWER_EXPONENT:     prdata = power_exponent_r;
      REG_DOF_AT_LEAST_THREE: prdata = {31'd0, dof_at_least_three_r};
      default:                prdata = '0;
    endcase
  end

  always_comb begin
    cfg.ratio_scale        = ratio_scale_r;
    cfg.squeeze_coeff      = squeeze_coeff_r;
    cfg.reject_bound       = reject_bound_r;
    cfg.inverse_dof        = inverse_dof_r;
    cfg.power_exponent     = power_exponent_r;
    cfg.dof_at_least_three = dof_at_least_three_r;
  end

  stru_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_u_uniform (in_u_uniform),
    .in_v_uniform (in_v_uniform),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (q_in)
  );

  stru_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  stru_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_sample    (out_sample),
    .out_saturated (out_saturated)
  );

`ifndef SYNTH
  a_zero_u_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_u_uniform == 32'd0 |-> !q_push)
    else $error("zero u request queued");
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == q_full) else $error("in_stall differs from queue full");
  a_dof_bit: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && reg_idx == REG_DOF_AT_LEAST_THREE |=> dof_at_least_three_r == $past(pwdata[0]))
    else $error("quick-reject enable not written");
`endif

endmodule
`default_nettype wire

/* sim/student_t_ratio_uniforms_sampler_checker.sv */
// Checker for the Student t sampler: tracks the registers, predicts trial outcomes, compares results.
`timescale 1ns / 1ps
module student_t_ratio_uniforms_sampler_checker import stru_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [31:0] in_u_uniform,
  input  wire logic [31:0] in_v_uniform,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [31:0] out_sample,
  input  wire logic        out_saturated,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic        pready,
  output int               errors,
  output int               pending,
  output int               results
);

  typedef struct {
    logic [31:0] sample;
    logic        saturated;
  } t_variate_t;

  stru_cfg_t    regs;
  t_variate_t   variate_q[$];

  // log2 of x >= 1 with 32 fraction bits, mantissa squared bit by bit
  function automatic logic [63:0] log2_q32(input logic [63:0] x);
    int          n;
    logic [63:0] m;
    logic [63:0] frac;
    n = 63;
    frac = 0;
    if (x == 0) return 0;
    while (x[n] == 1'b0) n--;
    m = (n >= 31) ? (x >> (n - 31)) : (x << (31 - n));
    for (int i = 0; i < 32; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        m = m >> 1;
        frac[0] = 1'b1;
      end
    end
    return (64'(n) << 32) | frac;
  endfunction

  // one ratio-of-uniforms trial; returns 1 when the pair yields a variate
  function automatic bit trial_accepts(input logic [31:0] u, input logic [31:0] v,
                                       input stru_cfg_t c, output t_variate_t r);
    logic [63:0]  wmag, tmag, sq, x, prod, y, qm, a, ly, mag;
    logic [127:0] full;
    bit           neg, ok;
    r.sample = 0;
    r.saturated = 0;
    if (u == 0) return 0;
    neg = v < 32'h8000_0000;
    wmag = neg ? 64'h1_0000_0000 - {31'b0, v, 1'b0} : {31'b0, v, 1'b0} - 64'h1_0000_0000;
    tmag = (64'(c.ratio_scale) * wmag) / 64'(u);
    full = 128'(tmag) * 128'(tmag);
    sq = (full[127:92] != 0) ? '1 : full[91:28];
    ok = (sq <= (64'd5 << 32)) &&
         (64'(c.squeeze_coeff) * 64'(u) <= (((64'd5 << 32) - sq) << 28));
    if (!ok && c.dof_at_least_three) begin
      x = sq + (64'd3 << 32);
      if (x < sq) x = '1;
      full = 128'(u) * 128'(x);
      if (full >= (128'(c.reject_bound) << 36)) return 0;
    end
    if (!ok) begin
      if (!c.power_exponent[31]) begin
        ok = 1;
      end else begin
        qm = 64'h1_0000_0000 - 64'($unsigned(c.power_exponent));
        full = 128'(sq) * 128'(c.inverse_dof);
        prod = (full[127:94] != 0) ? '1 : full[93:30];
        y = prod + 64'h1_0000_0000;
        if (y < prod) y = '1;
        a = (64'd32 << 32) - log2_q32(64'(u));
        ly = log2_q32(y) - (64'd32 << 32);
        full = 128'(qm) * 128'(ly);
        ok = (full[127:64] == 0) && (full[63:0] <= (a << 16));
      end
    end
    if (!ok) return 0;
    if (OUT_FRAC_BITS <= 30) begin
      mag = tmag >> (30 - OUT_FRAC_BITS);
    end else if (tmag > (64'd1 << 33)) begin
      mag = 64'd1 << 35;
    end else begin
      mag = tmag << (OUT_FRAC_BITS - 30);
    end
    if (neg) begin
      if (mag > 64'h8000_0000) begin
        mag = 64'h8000_0000;
        r.saturated = 1;
      end
      r.sample = 32'(64'd0 - mag);
    end else begin
      if (mag > 64'h7FFF_FFFF) begin
        mag = 64'h7FFF_FFFF;
        r.saturated = 1;
      end
      r.sample = mag[31:0];
    end
    return 1;
  endfunction

  always @(posedge clk) begin
    t_variate_t want, got;
    if (!rst_n) begin
      regs.ratio_scale        = 32'h4000_0000;
      regs.squeeze_coeff      = 32'd1518500250;
      regs.reject_bound       = 32'd759250125;
      regs.inverse_dof        = 32'h4000_0000;
      regs.power_exponent     = -32'sd32768;
      regs.dof_at_least_three = 1'b0;
      variate_q.delete();
      errors  = 0;
      results = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[4:2]))
          REG_RATIO_SCALE:        regs.ratio_scale        = pwdata;
          REG_SQUEEZE_COEFF:      regs.squeeze_coeff      = pwdata;
          REG_REJECT_BOUND:       regs.reject_bound       = pwdata;
          REG_INVERSE_DOF:        regs.inverse_dof        = pwdata;
          REG_POWER_EXPONENT:     regs.power_exponent     = pwdata;
          REG_DOF_AT_LEAST_THREE: regs.dof_at_least_three = pwdata[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (trial_accepts(in_u_uniform, in_v_uniform, regs, want)) variate_q.push_back(want);
      end
      if (out_valid && !out_stall) begin
        results++;
        if (variate_q.size() == 0) begin
          $error("unexpected result: sample %0d saturated %0d", $signed(out_sample),
                 out_saturated);
          errors++;
        end else begin
          got = variate_q.pop_front();
          if (out_sample !== got.sample) begin
            $error("sample mismatch: expected %0d, got %0d", $signed(got.sample),
                   $signed(out_sample));
            errors++;
          end
          if (out_saturated !== got.saturated) begin
            $error("saturated mismatch: expected %0d, got %0d", got.saturated, out_saturated);
            errors++;
          end
        end
      end
    end
    pending = variate_q.size();
  end

endmodule

/* sim/student_t_ratio_uniforms_sampler_core_test.sv */
// Testbench top for the Student t sampler: clock, reset, requests, register writes, verdict.
`timescale 1ns / 1ps
module student_t_ratio_uniforms_sampler_core_test;
  import stru_pkg::*;

  localparam int IDLE_LIMIT = 3000;
  localparam int SETTLE     = 150;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [31:0] in_u_uniform = 0;
  logic [31:0] in_v_uniform = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic signed [31:0] out_sample;
  logic        out_saturated;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [4:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;

  int errors, pending, results;
  int n_sent = 0;
  int hold_left = 0;
  bit held = 0;
  int quiet_cycles = 0;

  always #6 clk = ~clk;

  student_t_ratio_uniforms_sampler_core uut (.*);

  student_t_ratio_uniforms_sampler_checker chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_u_uniform, .in_v_uniform,
    .out_valid, .out_stall, .out_sample, .out_saturated,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .errors, .pending, .results
  );

  function automatic bit no_idle_stretch();
    return n_sent >= 220 && n_sent < 290;
  endfunction

  // receiver: random stalls, one long hold-off once 150 requests have been sent
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 0;
    end else if (hold_left != 0) begin
      out_stall <= 1;
      hold_left <= hold_left - 1;
    end else if (!held && n_sent >= 150) begin
      held      <= 1;
      hold_left <= 300;
      out_stall <= 1;
    end else begin
      out_stall <= no_idle_stretch() ? 1'b0 : ($urandom_range(99) < 23);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
      quiet_cycles <= 0;
    else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  task automatic send_request(input logic [31:0] u, input logic [31:0] v);
    while (!no_idle_stretch() && $urandom_range(99) < 23) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid     <= 1;
    in_u_uniform <= u;
    in_v_uniform <= v;
    do @(posedge clk); while (in_stall);
    n_sent <= n_sent + 1;
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    psel    <= 1;
    penable <= 0;
    pwrite  <= 1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel    <= 0;
    penable <= 0;
    pwrite  <= 0;
    @(posedge clk);
  endtask

  task automatic set_params(input logic [31:0] vm, c, e, r, q, input logic dof3);
    write_reg(REG_RATIO_SCALE, vm);
    write_reg(REG_SQUEEZE_COEFF, c);
    write_reg(REG_REJECT_BOUND, e);
    write_reg(REG_INVERSE_DOF, r);
    write_reg(REG_POWER_EXPONENT, q);
    write_reg(REG_DOF_AT_LEAST_THREE, {31'b0, dof3});
  endtask

  // hold input until every expected variate is out, then let rejects flush
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    wait (pending == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_u();
    logic [31:0] u;
    case ($urandom_range(3))
      0: u = $urandom;
      1: u = $urandom >> $urandom_range(31);
      2: u = 32'hFFFF_FFFF - $urandom_range(255);
      default: u = 32'h8000_0000 | $urandom;
    endcase
    return (u == 0) ? 32'd1 : u;
  endfunction

  function automatic logic [31:0] pick_v();
    if ($urandom_range(3) == 0) return 32'h8000_0000 + $urandom_range(511) - 256;
    return $urandom;
  endfunction

  task automatic random_phase(input int min_items);
    int start, items;
    start = results;
    items = 0;
    while (items < min_items || (results - start < 30 && items < 200)) begin
      send_request(pick_u(), pick_v());
      items++;
    end
    drain();
  endtask

  initial begin
    logic [31:0] dir_u[] = '{32'd1, 32'hFFFF_FFFF, 32'h8000_0000, 32'd1, 32'hFFFF_FFFF,
                             32'h0000_0100, 32'h4000_0000, 32'hC000_0000, 32'd0, 32'd1,
                             32'hFFFF_FFFF, 32'h0001_0000, 32'h7FFF_FFFF, 32'h0000_0003};
    logic [31:0] dir_v[] = '{32'd0, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'd0,
                             32'h7FFF_FFFF, 32'h9000_0000, 32'h2000_0000, 32'h1234_5678,
                             32'h8000_0000, 32'h8000_0001, 32'h0000_FFFF, 32'hAAAA_AAAA,
                             32'h5555_5555};
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // extremes under the reset settings: zero t, saturation both ways, zero u
    foreach (dir_u[i]) send_request(dir_u[i], dir_v[i]);
    drain();
    set_params(32'h4000_0000, 32'd1518500250, 32'd759250125, 32'h4000_0000, -32'sd32768, 1);
    foreach (dir_u[i]) send_request(dir_u[i], dir_v[i]);
    drain();
    random_phase(60);

    // drop a write to an unmapped index
    write_reg(reg_idx_t'(3'd6), 32'hFFFF_FFFF);
    set_params(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 0);
    random_phase(40);
    set_params('1, '1, '1, '1, 32'h7FFF_FFFF, 1);
    random_phase(40);
    set_params(32'h4000_0000, 32'h0100_0000, 32'h0080_0000, '1, 32'h8000_0000, 1);
    random_phase(60);
    set_params(32'h3000_0000, 32'h1400_0000, 32'h0C00_0000, 32'h0CCC_CCCD, -32'sd98304, 1);
    random_phase(120);
    set_params($urandom, $urandom, $urandom, $urandom, $urandom | 32'h8000_0000, 0);
    random_phase(60);

    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
